// ===== rtl/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 61;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD_RD,
      ST_PAD_WR,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_RUN,
      ST_ADD,
      ST_EMIT
   } state_type;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   function automatic word_type rotr(word_type v, int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_if.sv =====
`default_nettype none
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   modport source (output valid, cmd, data_byte, input ready);
   modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
`default_nettype none
// SHA-256 over a byte stream.
// req channel: cmd 0 absorbs data_byte, cmd 1 finishes the message.
// rsp channel: eight digest words, word_index 0..7, last_word on the 8th.
// Absorbing a byte is a read-modify-write of the 16x32 block memory; the
// 64th byte of a block also runs the 64 rounds of the single round engine
// and folds the result into the hash. No new byte is accepted while a
// byte's write or a block's compression is still in flight.
// Finish places the pad byte, writes the remaining block words one per
// cycle, then starts the engine (64 rounds, then the fold). When the length
// does not fit, a second block of 16 words is written, compressed and
// folded. The first digest word is offered after the last fold, then one
// word per cycle while rsp.ready holds.
// Reset restores the initial hash and zero length; the block memory is not
// cleared since every entry is written before the engine reads it.
// When the receiver stalls, the current digest word holds on rsp and no
// new request is accepted until all eight words are taken.
module sha256_stream_hasher (
   input wire     clock,
   input wire     reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   import sha_pkg::*;

   // block memory, one write port, registered read
   word_type   blk_mem [16];
   word_type   blk_rd_ff;
   logic [3:0] rd_addr;
   logic       wr_en;
   logic [3:0] wr_addr;
   word_type   wr_data;

   word_type           hash_ff [8];
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   state_type          st_ff, st_in;
   logic [3:0]         wi_ff, wi_in;     // pad word pointer
   logic               two_ff, two_in;   // second block still needed
   logic               fin_ff, fin_in;   // compression belongs to finish
   logic [2:0]         oi_ff, oi_in;
   logic               byte_ff, byte_in; // byte absorb rmw in flight
   logic [7:0]         db_ff;
   logic               eng_start;
   logic               eng_done;
   logic [3:0]         eng_addr;
   word_type           v [8];
   logic               fold;
   logic [63:0]        bits;

   assign bits = {cnt_ff, 3'b000};

   sha_rounds u_rounds (
      .clock(clock), .reset(reset), .start(eng_start), .blk_word(blk_rd_ff),
      .blk_addr(eng_addr), .h_in(hash_ff), .v_out(v), .done(eng_done)
   );

   always_ff @(posedge clock) begin
      if (wr_en) blk_mem[wr_addr] <= wr_data;
      blk_rd_ff <= blk_mem[rd_addr];
   end

   always_comb begin
      logic [1:0] bp;
      logic [4:0] sh;
      bp        = cnt_ff[1:0];
      sh        = 5'd24 - {bp, 3'b000};
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      wi_in     = wi_ff;
      two_in    = two_ff;
      fin_in    = fin_ff;
      oi_in     = oi_ff;
      byte_in   = 1'b0;
      rd_addr   = cnt_ff[5:2];
      wr_en     = 1'b0;
      wr_addr   = cnt_ff[5:2];
      wr_data   = blk_rd_ff;
      eng_start = 1'b0;
      fold      = 1'b0;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            // merge byte into word read last cycle
            if (byte_ff) begin
               wr_en   = 1'b1;
               wr_data = (blk_rd_ff & ~(word_type'(8'hff) << sh))
                       | (word_type'(db_ff) << sh);
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff[5:0] == 6'd63) begin
                  eng_start = 1'b1;
                  fin_in    = 1'b0;
                  st_in     = ST_RUN;
               end
            end else begin
               req.ready = 1'b1;
               if (req.valid) begin
                  if (!req.cmd) byte_in = 1'b1;
                  else st_in = ST_PAD_RD;
               end
            end
         end
         ST_PAD_RD: st_in = ST_PAD_WR;  // word at pos now being read
         ST_PAD_WR: begin
            // pad byte into current word; a full last word goes straight to compression
            wr_en   = 1'b1;
            wr_data = (blk_rd_ff & ~(32'hffffffff >> {bp, 3'b000}))
                    | (word_type'(PAD_BYTE) << sh);
            wi_in   = cnt_ff[5:2] + 4'd1;
            two_in  = cnt_ff[5:0] >= LEN_START;
            st_in   = (cnt_ff[5:2] == 4'd15) ? ST_LEN_LO : ST_LEN_HI;
         end
         ST_LEN_HI: begin
            // zero words up to 13, then length words; all zero while a second block is needed
            wr_en   = 1'b1;
            wr_addr = wi_ff;
            wi_in   = wi_ff + 4'd1;
            if (two_ff || wi_ff < 4'd14) wr_data = '0;
            else if (wi_ff == 4'd14) wr_data = bits[63:32];
            else wr_data = bits[31:0];
            if (wi_ff == 4'd15) st_in = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            // block ready: compress it
            eng_start = 1'b1;
            fin_in    = !two_ff;
            st_in     = ST_RUN;
         end
         ST_RUN: begin
            rd_addr = eng_addr;
            if (eng_done) st_in = ST_ADD;
         end
         ST_ADD: begin
            fold = 1'b1;
            if (!fin_ff && !two_ff) st_in = ST_IDLE;
            else if (two_ff) begin
               two_in = 1'b0;
               wi_in  = 4'd0;
               st_in  = ST_LEN_HI;
            end else begin
               oi_in = '0;
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               oi_in = oi_ff + 3'd1;
               if (oi_ff == 3'd7) begin
                  st_in  = ST_IDLE;
                  cnt_in = '0;
                  fin_in = 1'b0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      // fetch the first round word while the engine starts
      if (eng_start) rd_addr = 4'd0;
   end

   assign rsp.digest_word = hash_ff[oi_ff];
   assign rsp.word_index  = oi_ff;
   assign rsp.last_word   = oi_ff == 3'd7;

   always_ff @(posedge clock) begin
      if (byte_in) db_ff <= req.data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         cnt_ff  <= '0;
         wi_ff   <= '0;
         two_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         oi_ff   <= '0;
         byte_ff <= 1'b0;
         hash_ff <= INIT_HASH;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         wi_ff   <= wi_in;
         two_ff  <= two_in;
         fin_ff  <= fin_in;
         oi_ff   <= oi_in;
         byte_ff <= byte_in;
         if (fold) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v[i];
         end
         if (st_ff == ST_EMIT && rsp.ready && oi_ff == 3'd7) hash_ff <= INIT_HASH;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sha_rounds.sv =====
`default_nettype none
// Round engine: 64 rounds, one per cycle, schedule kept in a 16-entry
// memory. Rounds 0..15 take w[i] from the block memory port via blk_addr;
// later rounds compute w[i] from w[i-16], w[i-15], w[i-7] and w[i-2] in the schedule ring, and each writes w[i] back.
module sha_rounds (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  sha_pkg::word_type      blk_word,  // block word for rounds 0..15
   output logic [3:0]             blk_addr,
   input  sha_pkg::word_type      h_in [8],
   output sha_pkg::word_type      v_out [8],
   output logic                   done
);
   import sha_pkg::*;

   // schedule ring: 16 registers read at fixed taps relative to round
   word_type   sched_ff [16];
   word_type   v_ff [8];
   logic [6:0] rnd_ff, rnd_in;
   logic       busy_ff, busy_in;
   word_type   w_cur, s0, s1, t1, t2;
   logic [3:0] ri;

   assign ri       = rnd_ff[3:0];
   assign blk_addr = rnd_in[3:0];

   always_comb begin
      s0 = rotr(sched_ff[ri+4'd1], 7) ^ rotr(sched_ff[ri+4'd1], 18)
         ^ (sched_ff[ri+4'd1] >> 3);
      s1 = rotr(sched_ff[ri-4'd2], 17) ^ rotr(sched_ff[ri-4'd2], 19)
         ^ (sched_ff[ri-4'd2] >> 10);
      if (rnd_ff < 7'd16) w_cur = blk_word;
      else w_cur = sched_ff[ri] + s0 + sched_ff[ri-4'd7] + s1;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[rnd_ff[5:0]] + w_cur;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      if (start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
      end else if (busy_ff) begin
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd63) busy_in = 1'b0;
      end
   end

   assign done  = busy_ff && rnd_ff == 7'd63;
   assign v_out = v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
      end
   end

   // advance working variables
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= h_in;
      end else if (busy_ff) begin
         sched_ff[ri] <= w_cur;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sha_checker.sv =====
`default_nettype none
module sha_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_word_index,
   input wire       rsp_last_word
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last flag mismatch");
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word skipped");
   a_noreq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during digest");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("stalled word moved");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_last_word(rsp.last_word)
);
`default_nettype wire
